@@ rtl/core/rzr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzr_pkg
// Shared types and constants of the rotate-and-zoom remap block.
// ----------------------------------------------------------------------------
package rzr_pkg;

  // Frame geometry and coefficient format
  localparam int FRAME_WIDTH    = 512;
  localparam int FRAME_HEIGHT   = 288;
  localparam int FRAME_DEPTH    = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int COEF_FRAC_BITS = 12;

  // Field widths
  localparam int POS_W   = 9;
  localparam int COLOR_W = 8;
  localparam int RGB_W   = 3 * COLOR_W;
  localparam int COEF_W  = 18;
  localparam int PIV_W   = 12;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 2;

  // Datapath widths
  localparam int DELTA_W = PIV_W + 1;                  // pos minus pivot
  localparam int PROD_W  = COEF_W + DELTA_W;           // coefficient times delta
  localparam int SUM_W   = PROD_W + 2;                 // two products plus pivot
  localparam int TRUNC_W = SUM_W - COEF_FRAC_BITS;     // integer source coordinate
  localparam int X_W     = $clog2(FRAME_WIDTH);
  localparam int Y_W     = $clog2(FRAME_HEIGHT);
  localparam int ADDR_W  = $clog2(FRAME_DEPTH);

  // Reset values of the configuration registers
  localparam logic signed [COEF_W-1:0] COS_RESET     = 18'sd4096;
  localparam logic signed [COEF_W-1:0] SIN_RESET     = 18'sd0;
  localparam logic signed [PIV_W-1:0]  PIVOT_X_RESET = 12'sd256;
  localparam logic signed [PIV_W-1:0]  PIVOT_Y_RESET = 12'sd144;

  // Item operation codes
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_PRODUCE = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS     = 2'd0,
    REG_SIN     = 2'd1,
    REG_PIVOT_X = 2'd2,
    REG_PIVOT_Y = 2'd3
  } rzr_reg_t;

  // Frame store request from the mapping pipeline
  typedef struct packed {
    logic              op;    // load or produce
    logic              ok;    // load in frame, or source inside frame
    logic [ADDR_W-1:0] addr;
    logic [RGB_W-1:0]  rgb;
  } rzr_req_t;

endpackage

@@ rtl/core/rzr_map.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzr_map
// Five-stage coordinate pipeline: pivot offset, four products, rotation
// sums, truncation toward zero with frame check, row-major address.
// ----------------------------------------------------------------------------
module rzr_map import rzr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic signed [COEF_W-1:0] cos_over_scale,
  input  logic signed [COEF_W-1:0] sin_over_scale,
  input  logic signed [PIV_W-1:0]  pivot_x,
  input  logic signed [PIV_W-1:0]  pivot_y,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     operation,
  input  logic [POS_W-1:0]         pos_x,
  input  logic [POS_W-1:0]         pos_y,
  input  logic [RGB_W-1:0]         rgb_in,
  output logic                     req_valid,
  input  logic                     req_ready,
  output rzr_req_t                 req
);

  // Valid bits and per-stage ready
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Common payload carried along
  logic              op1, op2, op3, op4, op5;
  logic [POS_W-1:0]  px1, px2, px3, px4;
  logic [POS_W-1:0]  py1, py2, py3, py4;
  logic [RGB_W-1:0]  rgb1, rgb2, rgb3, rgb4, rgb5;

  // Stage 1: offsets from pivot
  logic signed [DELTA_W-1:0] dx1, dy1;
  // Stage 2: products
  logic signed [PROD_W-1:0]  cdx2, sdy2, sdx2, cdy2;
  // Stage 3: full-precision sums
  logic signed [SUM_W-1:0]   xsum3, ysum3;
  // Stage 4: integer coordinates and range flag
  logic signed [TRUNC_W-1:0] xt4, yt4;
  logic                      ok4;
  // Stage 5: address
  logic                      ok5;
  logic [ADDR_W-1:0]         addr5;

  logic signed [DELTA_W-1:0] dx_next, dy_next;
  logic signed [SUM_W-1:0]   xsum_next, ysum_next;
  logic signed [SUM_W-1:0]   xbias, ybias;
  logic signed [SUM_W-1:0]   xadj, yadj;
  logic                      xin, yin, ld_ok;
  logic [X_W-1:0]            sel_x;
  logic [Y_W-1:0]            sel_y;

  // Stage ready: empty, or the stage after it moves
  assign rdy5     = !v5 || req_ready;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Offsets from the rotation center
  assign dx_next = $signed({{(DELTA_W-POS_W){1'b0}}, pos_x})
                 - $signed({pivot_x[PIV_W-1], pivot_x});
  assign dy_next = $signed({{(DELTA_W-POS_W){1'b0}}, pos_y})
                 - $signed({pivot_y[PIV_W-1], pivot_y});

  // Rotation sums with the pivot moved back in, at full precision
  assign xsum_next = $signed({{2{cdx2[PROD_W-1]}}, cdx2})
                   - $signed({{2{sdy2[PROD_W-1]}}, sdy2})
                   + $signed({{(SUM_W-PIV_W-COEF_FRAC_BITS){pivot_x[PIV_W-1]}}, pivot_x,
                              {COEF_FRAC_BITS{1'b0}}});
  assign ysum_next = $signed({{2{sdx2[PROD_W-1]}}, sdx2})
                   + $signed({{2{cdy2[PROD_W-1]}}, cdy2})
                   + $signed({{(SUM_W-PIV_W-COEF_FRAC_BITS){pivot_y[PIV_W-1]}}, pivot_y,
                              {COEF_FRAC_BITS{1'b0}}});

  // Truncate toward zero: bias negative sums by one less than one unit
  assign xbias = xsum3[SUM_W-1] ? $signed({{(SUM_W-COEF_FRAC_BITS){1'b0}},
                                           {COEF_FRAC_BITS{1'b1}}}) : '0;
  assign ybias = ysum3[SUM_W-1] ? $signed({{(SUM_W-COEF_FRAC_BITS){1'b0}},
                                           {COEF_FRAC_BITS{1'b1}}}) : '0;
  assign xadj  = xsum3 + xbias;
  assign yadj  = ysum3 + ybias;

  // Frame checks
  assign ld_ok = ({{(32-POS_W){1'b0}}, px3} < 32'(FRAME_WIDTH))
              && ({{(32-POS_W){1'b0}}, py3} < 32'(FRAME_HEIGHT));

  always_comb begin
    xin = !xadj[SUM_W-1]
       && ($unsigned(xadj[SUM_W-1:COEF_FRAC_BITS]) < TRUNC_W'(FRAME_WIDTH));
    yin = !yadj[SUM_W-1]
       && ($unsigned(yadj[SUM_W-1:COEF_FRAC_BITS]) < TRUNC_W'(FRAME_HEIGHT));
  end

  // Pick the pixel position: source for produce, own position for load
  always_comb begin
    if (op4 == OP_PRODUCE) begin
      sel_x = xt4[X_W-1:0];
      sel_y = yt4[Y_W-1:0];
    end else begin
      sel_x = X_W'(px4);
      sel_y = Y_W'(py4);
    end
  end

  // Payload registers, each advancing with its stage
  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1  <= operation;
      px1  <= pos_x;
      py1  <= pos_y;
      rgb1 <= rgb_in;
      dx1  <= dx_next;
      dy1  <= dy_next;
    end
    if (rdy2) begin
      op2  <= op1;
      px2  <= px1;
      py2  <= py1;
      rgb2 <= rgb1;
      cdx2 <= cos_over_scale * dx1;
      sdy2 <= sin_over_scale * dy1;
      sdx2 <= sin_over_scale * dx1;
      cdy2 <= cos_over_scale * dy1;
    end
    if (rdy3) begin
      op3   <= op2;
      px3   <= px2;
      py3   <= py2;
      rgb3  <= rgb2;
      xsum3 <= xsum_next;
      ysum3 <= ysum_next;
    end
    if (rdy4) begin
      op4  <= op3;
      px4  <= px3;
      py4  <= py3;
      rgb4 <= rgb3;
      xt4  <= xadj[SUM_W-1:COEF_FRAC_BITS];
      yt4  <= yadj[SUM_W-1:COEF_FRAC_BITS];
      ok4  <= (op3 == OP_PRODUCE) ? (xin && yin) : ld_ok;
    end
    if (rdy5) begin
      op5   <= op4;
      rgb5  <= rgb4;
      ok5   <= ok4;
      addr5 <= ADDR_W'(32'(sel_y) * FRAME_WIDTH) + ADDR_W'(sel_x);
    end
  end

  assign req_valid = v5;
  assign req.op    = op5;
  assign req.ok    = ok5;
  assign req.addr  = addr5;
  assign req.rgb   = rgb5;

  // A produce item flagged inside carries coordinates within the frame
  a_inside_range: assert property (@(posedge clk) disable iff (rst)
    (v4 && op4 == OP_PRODUCE && ok4) |->
      (!xt4[TRUNC_W-1] && !yt4[TRUNC_W-1]
       && $unsigned(xt4) < TRUNC_W'(FRAME_WIDTH)
       && $unsigned(yt4) < TRUNC_W'(FRAME_HEIGHT)))
    else $error("inside flag with source out of frame");

  // A valid address never exceeds the frame store
  a_addr_range: assert property (@(posedge clk) disable iff (rst)
    (v5 && ok5) |-> (32'(addr5) < FRAME_DEPTH))
    else $error("frame store address out of range");

  // A stalled request holds in the last stage
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (v5 && !req_ready) |=> (v5 && $stable(addr5) && $stable(op5) && $stable(ok5)))
    else $error("stalled request changed");

  // A stage that cannot move keeps its item
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !rdy3) |=> v2)
    else $error("item dropped in stalled stage");

endmodule

@@ rtl/core/rzr_frame_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rzr_frame_store
// Single-port pixel memory with registered read; also the output register
// of the block. Loads write, produce items read, in arrival order.
// ----------------------------------------------------------------------------
module rzr_frame_store import rzr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  rzr_req_t            req,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [COLOR_W-1:0]  red_out,
  output logic [COLOR_W-1:0]  green_out,
  output logic [COLOR_W-1:0]  blue_out,
  output logic                outside
);

  logic [RGB_W-1:0] mem [FRAME_DEPTH];
  logic [RGB_W-1:0] rd_data;
  logic             v, op, ok;
  logic             adv;

  // Take a new request unless a result waits
  assign adv       = !(v && op == OP_PRODUCE) || out_ready;
  assign req_ready = adv;

  // Memory: write loads in frame, read every cycle the stage advances
  always_ff @(posedge clk) begin
    if (adv) begin
      if (req_valid && req.op == OP_LOAD && req.ok) begin
        mem[req.addr] <= req.rgb;
      end
      rd_data <= mem[req.addr];
    end
  end

  // Stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (adv) begin
      v <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      op <= req.op;
      ok <= req.ok;
    end
  end

  // Drive the result; black when the source lies outside
  assign out_valid = v && op == OP_PRODUCE;
  assign outside   = !ok;
  assign red_out   = ok ? rd_data[RGB_W-1 -: COLOR_W]   : '0;
  assign green_out = ok ? rd_data[2*COLOR_W-1 -: COLOR_W] : '0;
  assign blue_out  = ok ? rd_data[COLOR_W-1:0]         : '0;

  // A waiting result blocks the next request
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !req_ready)
    else $error("request taken over a waiting result");

  // A load leaves without a result
  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    (adv && req_valid && req.op == OP_LOAD) |=> !out_valid)
    else $error("load produced a result");

  // Outside results are black
  a_outside_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && outside) |-> (red_out == '0 && green_out == '0 && blue_out == '0))
    else $error("outside result not black");

endmodule

@@ rtl/core/rotate_zoom_remap.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotate_zoom_remap
// Frame store with nearest-neighbor rotate-and-zoom readout.
// ----------------------------------------------------------------------------
// Load transactions write one RGB pixel; produce transactions map a
// destination pixel back through the configured Q.12 coefficients around the
// pivot and return the source pixel, or black with outside set. The block
// takes one transaction per cycle while the output is not stalled. A produce
// result passes through the five mapping stages, the first loaded at the
// accepting edge, and then through the registered memory read. The
// single-port frame store, which serves one write or one read per cycle,
// sets that rate. Transactions complete in order, so a produce always sees
// every earlier load. The store is not cleared after reset: read only
// pixels that were loaded. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
module rotate_zoom_remap import rzr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [POS_W-1:0]      pos_x,
  input  logic [POS_W-1:0]      pos_y,
  input  logic [COLOR_W-1:0]    red_in,
  input  logic [COLOR_W-1:0]    green_in,
  input  logic [COLOR_W-1:0]    blue_in,
  // output channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COLOR_W-1:0]    red_out,
  output logic [COLOR_W-1:0]    green_out,
  output logic [COLOR_W-1:0]    blue_out,
  output logic                  outside
);

  logic signed [COEF_W-1:0] cos_over_scale, sin_over_scale;
  logic signed [PIV_W-1:0]  pivot_x, pivot_y;
  logic                     req_valid, req_ready;
  rzr_req_t                 req;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_over_scale <= COS_RESET;
      sin_over_scale <= SIN_RESET;
      pivot_x        <= PIVOT_X_RESET;
      pivot_y        <= PIVOT_Y_RESET;
    end else if (cfg_write) begin
      case (rzr_reg_t'(cfg_index))
        REG_COS:     cos_over_scale <= $signed(cfg_data[COEF_W-1:0]);
        REG_SIN:     sin_over_scale <= $signed(cfg_data[COEF_W-1:0]);
        REG_PIVOT_X: pivot_x        <= $signed(cfg_data[PIV_W-1:0]);
        REG_PIVOT_Y: pivot_y        <= $signed(cfg_data[PIV_W-1:0]);
        default: ;
      endcase
    end
  end

  // Coordinate pipeline
  rzr_map u_map (
    .clk            (clk),
    .rst            (rst),
    .cos_over_scale (cos_over_scale),
    .sin_over_scale (sin_over_scale),
    .pivot_x        (pivot_x),
    .pivot_y        (pivot_y),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .operation      (operation),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .rgb_in         ({red_in, green_in, blue_in}),
    .req_valid      (req_valid),
    .req_ready      (req_ready),
    .req            (req)
  );

  // Pixel memory and result register
  rzr_frame_store u_store (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .outside   (outside)
  );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotate-and-zoom remap block.
// ----------------------------------------------------------------------------
// Sends load and produce transactions over the valid/ready input channel.
// The bench keeps its own copy of the frame store and of the inverse mapping,
// and checks every produce result in order against it. Coefficient and pivot
// settings change between batches, only once the block has drained. Both
// channels stall at random, first sender-light, then sender-heavy, then not
// at all. A produce never reads a pixel that was not loaded: when the mapped
// source is inside the frame and still empty, the bench loads it first.
// ----------------------------------------------------------------------------
module tb_top;
  import rzr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transaction
  localparam int DRAIN_CYCLES   = 12;    // slack for loads still in flight
  localparam int MAX_REPORTS    = 10;
  localparam int BATCH_ITEMS    = 100;

  typedef struct {
    logic               op;
    logic [POS_W-1:0]   x;
    logic [POS_W-1:0]   y;
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
  } pixel_txn_t;

  typedef struct {
    logic [COLOR_W-1:0] r;
    logic [COLOR_W-1:0] g;
    logic [COLOR_W-1:0] b;
    logic               outside;
  } pixel_result_t;

  // DUT inputs, all known from time zero
  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_COS;
  logic [CFG_W-1:0]     cfg_data  = '0;
  logic                 in_valid  = 1'b0;
  logic                 operation = OP_LOAD;
  logic [POS_W-1:0]     pos_x     = '0;
  logic [POS_W-1:0]     pos_y     = '0;
  logic [COLOR_W-1:0]   red_in    = '0;
  logic [COLOR_W-1:0]   green_in  = '0;
  logic [COLOR_W-1:0]   blue_in   = '0;
  logic                 out_ready = 1'b0;

  // DUT outputs
  logic                 in_ready;
  logic                 out_valid;
  logic [COLOR_W-1:0]   red_out;
  logic [COLOR_W-1:0]   green_out;
  logic [COLOR_W-1:0]   blue_out;
  logic                 outside;

  // Mirror of the block: registers, frame store and results in flight
  logic signed [COEF_W-1:0] cos_coef  = COS_RESET;
  logic signed [COEF_W-1:0] sin_coef  = SIN_RESET;
  logic signed [PIV_W-1:0]  pivot_col = PIVOT_X_RESET;
  logic signed [PIV_W-1:0]  pivot_row = PIVOT_Y_RESET;
  logic [RGB_W-1:0]         pixel_mem    [FRAME_DEPTH];
  bit                       pixel_loaded [FRAME_DEPTH];
  pixel_result_t            pending_pixels [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int checked_count = 0;
  int load_count    = 0;
  int ignored_count = 0;
  int produce_count = 0;
  int outside_count = 0;
  int setting_count = 0;

  rotate_zoom_remap DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .red_in    (red_in),
    .green_in  (green_in),
    .blue_in   (blue_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_out   (red_out),
    .green_out (green_out),
    .blue_out  (blue_out),
    .outside   (outside)
  );

  // Generate the clock
  initial begin
    forever #4 clk = ~clk;
  end

  // Map a destination pixel back to its source, truncated toward zero
  function automatic void map_to_source(input logic [POS_W-1:0] x,
                                        input logic [POS_W-1:0] y,
                                        output longint sx, output longint sy);
    longint dx, dy, unit;
    unit = longint'(1) << COEF_FRAC_BITS;
    dx = longint'(x) - longint'(pivot_col);
    dy = longint'(y) - longint'(pivot_row);
    sx = (longint'(cos_coef) * dx - longint'(sin_coef) * dy
          + longint'(pivot_col) * unit) / unit;
    sy = (longint'(sin_coef) * dx + longint'(cos_coef) * dy
          + longint'(pivot_row) * unit) / unit;
  endfunction

  function automatic bit in_frame(input longint sx, input longint sy);
    return sx >= 0 && sx < FRAME_WIDTH && sy >= 0 && sy < FRAME_HEIGHT;
  endfunction

  function automatic int frame_index(input longint sx, input longint sy);
    return int'(sy) * FRAME_WIDTH + int'(sx);
  endfunction

  function automatic void note_failure(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("MISMATCH: %s", msg);
  endfunction

  // Drive one transaction, wait for acceptance, then update the mirror
  task automatic send_txn(input pixel_txn_t t);
    int            gap;
    int            idx;
    longint        sx, sy;
    pixel_result_t res;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= t.op;
    pos_x     <= t.x;
    pos_y     <= t.y;
    red_in    <= t.r;
    green_in  <= t.g;
    blue_in   <= t.b;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (t.op == OP_LOAD) begin
      if (t.x < FRAME_WIDTH && t.y < FRAME_HEIGHT) begin
        idx = frame_index(longint'(t.x), longint'(t.y));
        pixel_mem[idx]    = {t.r, t.g, t.b};
        pixel_loaded[idx] = 1'b1;
        load_count++;
      end else begin
        ignored_count++;
      end
    end else begin
      map_to_source(t.x, t.y, sx, sy);
      if (in_frame(sx, sy)) begin
        idx = frame_index(sx, sy);
        res.r       = pixel_mem[idx][23:16];
        res.g       = pixel_mem[idx][15:8];
        res.b       = pixel_mem[idx][7:0];
        res.outside = 1'b0;
      end else begin
        res.r       = '0;
        res.g       = '0;
        res.b       = '0;
        res.outside = 1'b1;
        outside_count++;
      end
      pending_pixels.push_back(res);
      produce_count++;
    end
  endtask

  task automatic load_pixel(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input logic [RGB_W-1:0] rgb);
    pixel_txn_t t;
    t.op = OP_LOAD;
    t.x  = x;
    t.y  = y;
    t.r  = rgb[23:16];
    t.g  = rgb[15:8];
    t.b  = rgb[7:0];
    send_txn(t);
  endtask

  // Produce a destination pixel; load its source first when it is still empty,
  // or always when refresh asks for a write right before the read
  task automatic produce_at(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                            input bit refresh);
    pixel_txn_t t;
    longint     sx, sy;
    map_to_source(x, y, sx, sy);
    if (in_frame(sx, sy) && (refresh || !pixel_loaded[frame_index(sx, sy)]))
      load_pixel(sx[POS_W-1:0], sy[POS_W-1:0], RGB_W'($urandom()));
    t.op = OP_PRODUCE;
    t.x  = x;
    t.y  = y;
    t.r  = COLOR_W'($urandom());
    t.g  = COLOR_W'($urandom());
    t.b  = COLOR_W'($urandom());
    send_txn(t);
  endtask

  // Drain the block, then write all four registers on consecutive cycles
  task automatic apply_setting(input int c, input int s, input int px, input int py);
    logic [COEF_W-1:0] c_word, s_word;
    logic [PIV_W-1:0]  px_word, py_word;
    logic [5:0]        px_pad, py_pad;
    c_word  = COEF_W'(c);
    s_word  = COEF_W'(s);
    px_word = PIV_W'(px);
    py_word = PIV_W'(py);
    px_pad  = 6'($urandom());
    py_pad  = 6'($urandom());
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= REG_COS;
    cfg_data  <= c_word;
    @(posedge clk);
    cfg_index <= REG_SIN;
    cfg_data  <= s_word;
    @(posedge clk);
    // upper bits of a pivot word are don't-care; drive them at random
    cfg_index <= REG_PIVOT_X;
    cfg_data  <= {px_pad, px_word};
    @(posedge clk);
    cfg_index <= REG_PIVOT_Y;
    cfg_data  <= {py_pad, py_word};
    @(posedge clk);
    cfg_write <= 1'b0;
    cos_coef  = c_word;
    sin_coef  = s_word;
    pivot_col = px_word;
    pivot_row = py_word;
    setting_count++;
  endtask

  task automatic test_identity_readback();
    // reset setting maps every pixel onto itself
    load_pixel(9'd0, 9'd0, 24'hFF00FF);
    load_pixel(9'd511, 9'd287, 24'h00FF00);
    load_pixel(9'd511, 9'd511, 24'hFFFFFF);
    load_pixel(9'd0, 9'd300, 24'h000000);
    produce_at(9'd0, 9'd0, 1'b0);
    produce_at(9'd511, 9'd287, 1'b0);
    produce_at(9'd511, 9'd511, 1'b0);
    produce_at(9'd0, 9'd287, 1'b0);
  endtask

  task automatic test_truncation_near_zero();
    // source at -0.5 on both axes still counts as inside
    apply_setting(2048, 0, -1, -1);
    produce_at(9'd0, 9'd0, 1'b0);
    // source at -1.5 falls outside
    apply_setting(1024, 0, -2, -2);
    produce_at(9'd0, 9'd0, 1'b0);
  endtask

  task automatic test_collapsed_mapping();
    // zero coefficients send every destination to the pivot
    apply_setting(0, 0, 5, 7);
    produce_at(9'd100, 9'd200, 1'b0);
    produce_at(9'd511, 9'd511, 1'b0);
  endtask

  task automatic test_extreme_settings();
    apply_setting(131071, -131072, 2047, -2048);
    produce_at(9'd0, 9'd0, 1'b0);
    produce_at(9'd511, 9'd287, 1'b0);
    produce_at(9'd0, 9'd511, 1'b0);
    apply_setting(-131072, 131071, -2048, 2047);
    produce_at(9'd0, 9'd0, 1'b0);
    produce_at(9'd511, 9'd0, 1'b0);
    produce_at(9'd511, 9'd511, 1'b0);
  endtask

  task automatic test_quarter_turn();
    apply_setting(0, 4096, 256, 144);
    produce_at(9'd256, 9'd144, 1'b1);
    produce_at(9'd300, 9'd100, 1'b0);
    produce_at(9'd10, 9'd280, 1'b0);
  endtask

  // Pick a coefficient set and pivot: mild, near identity, full range, quarter turns
  task automatic random_setting();
    int c, s, px, py, mag;
    case ($urandom_range(3))
      0: begin
        c = int'($urandom_range(12288)) - 6144;
        s = int'($urandom_range(12288)) - 6144;
      end
      1: begin
        c = 4096 + int'($urandom_range(512)) - 256;
        s = int'($urandom_range(512)) - 256;
      end
      2: begin
        c = int'($urandom_range(262143)) - 131072;
        s = int'($urandom_range(262143)) - 131072;
      end
      default: begin
        mag = ($urandom_range(1) != 0) ? 4096 : 2048;
        case ($urandom_range(3))
          0: begin c = mag;  s = 0;    end
          1: begin c = 0;    s = mag;  end
          2: begin c = -mag; s = 0;    end
          default: begin c = 0; s = -mag; end
        endcase
      end
    endcase
    if ($urandom_range(9) == 0) begin
      px = int'($urandom_range(4095)) - 2048;
      py = int'($urandom_range(4095)) - 2048;
    end else begin
      px = int'($urandom_range(FRAME_WIDTH - 1));
      py = int'($urandom_range(FRAME_HEIGHT - 1));
    end
    apply_setting(c, s, px, py);
  endtask

  // Mix loads and produces; off-frame loads are dropped and not counted
  task automatic run_random_batch(input int count);
    int               done, pick;
    logic [POS_W-1:0] y;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        load_pixel(POS_W'($urandom_range(511)), POS_W'(288 + $urandom_range(223)),
                   RGB_W'($urandom()));
      end else if (pick < 40) begin
        load_pixel(POS_W'($urandom_range(511)), POS_W'($urandom_range(FRAME_HEIGHT - 1)),
                   RGB_W'($urandom()));
        done++;
      end else begin
        if ($urandom_range(9) == 0) y = POS_W'(288 + $urandom_range(223));
        else y = POS_W'($urandom_range(FRAME_HEIGHT - 1));
        produce_at(POS_W'($urandom_range(511)), y, $urandom_range(9) == 0);
        done++;
      end
    end
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      random_setting();
      run_random_batch(BATCH_ITEMS);
    end
  endtask

  // Stall the output channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_result
    pixel_result_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_pixels.size() == 0) begin
        note_failure($sformatf("unexpected result rgb %02h %02h %02h outside %0b",
                               red_out, green_out, blue_out, outside));
      end else begin
        want = pending_pixels.pop_front();
        if (red_out !== want.r || green_out !== want.g || blue_out !== want.b ||
            outside !== want.outside)
          note_failure($sformatf({"result %0d expected rgb %02h %02h %02h outside %0b,",
                                  " got rgb %02h %02h %02h outside %0b"},
                                 checked_count, want.r, want.g, want.b, want.outside,
                                 red_out, green_out, blue_out, outside));
        checked_count++;
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("Timeout: %0d cycles without a transaction, %0d results outstanding",
             quiet, pending_pixels.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Run the tests in turn
  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 28;
    recv_idle_pct = 84;
    test_identity_readback();
    test_truncation_near_zero();
    test_collapsed_mapping();
    test_extreme_settings();
    test_quarter_turn();
    test_random_traffic(28, 84);
    test_random_traffic(84, 28);
    test_random_traffic(0, 0);
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d stored loads, %0d ignored off-frame loads, %0d produces",
             load_count, ignored_count, produce_count);
    $display("Checked %0d results (%0d outside) over %0d register settings in mixed traffic",
             checked_count, outside_count, setting_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d failures", error_count);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/rzr_pkg.sv
rtl/core/rzr_map.sv
rtl/core/rzr_frame_store.sv
rtl/core/rotate_zoom_remap.sv
tb/tb_top.sv
